@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL; compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define HHRC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("hhrc assertion failed");
// Condition must never be seen outside reset.
`define HHRC_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("hhrc forbidden condition seen");
`else
`define HHRC_ASSERT(lbl, clk, rst_n, prop)
`define HHRC_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

@@ rtl/hhrc_pkg.sv @@
package hhrc_pkg;

    localparam int unsigned HISTORY_DEPTH_DEF = 256;
    localparam int unsigned FUNC_W            = 3;
    localparam int unsigned KEY_W             = 64;
    localparam int unsigned OUT_W             = 9;
    localparam int unsigned IN_TDATA_W        = 72;
    localparam int unsigned OUT_TDATA_W       = 24;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH      = 3'd0,
        FN_POP       = 3'd1,
        FN_CLEAR     = 3'd2,
        FN_COUNT_KEY = 3'd3,
        FN_COUNT_TOP = 3'd4
    } t_func;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_TOPRD = 6'b000010,
        ST_TOPLD = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_DONE  = 6'b010000,
        ST_SPARE = 6'b100000
    } t_state;

endpackage

@@ rtl/hhrc_ram.sv @@
module hhrc_ram
    import hhrc_pkg::*;
#(
    parameter int unsigned WIDTH = KEY_W,
    parameter int unsigned DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/hash_history_repeat_counter.sv @@
// Repetition history table: a bounded stack of 64-bit position keys.
// Input stream (s_axis): one transfer carries one operation, func and key.
//   push appends the key (when full the oldest key is dropped), pop removes
//   the top key, clear empties the table, count-key counts held keys equal
//   to the key, count-top counts held keys equal to the top key.
// Output stream (m_axis): exactly one transfer per operation, carrying the
//   match count (0 for push, pop, clear and unused codes) and the fill level
//   after the operation.
// Keys live in a circular buffer in one RAM with a registered read; a base
// pointer marks the oldest key, so a push into a full table just overwrites
// it. The count operations sweep the held keys through one shared 64-bit
// comparator, one RAM read per cycle.
// Push, pop and clear need no sweep; count-key sweeps the N held keys and
// count-top first reads the top key, then sweeps them (no sweep when empty);
// N = fill level, one RAM read per key. tready is high only while idle.
// Reset empties the table (no clearing pass; unwritten keys are never read)
// and drops any pending result. A stalled receiver holds the result in the
// output register; the next operation may be accepted meanwhile, and its
// result waits until the register frees.
module hash_history_repeat_counter
    import hhrc_pkg::*;
#(
    parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [2:0] func, [66:3] key, [71:67] zero
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [8:0] match_count, [17:9] fill_level, [23:18] zero
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

`include "assert_macros.svh"

    localparam int unsigned AW = $clog2(HISTORY_DEPTH);     // RAM index
    localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1); // fill count
    localparam int unsigned PW = AW + 1;                    // base + count

    localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
    localparam logic [PW-1:0] DEPTH_P = PW'(HISTORY_DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(HISTORY_DEPTH - 1);

    // unpack the input transfer
    logic [FUNC_W-1:0] in_func;
    logic [KEY_W-1:0]  in_key;
    logic              in_xfer;

    assign in_func = i_s_axis_tdata[FUNC_W-1:0];
    assign in_key  = i_s_axis_tdata[FUNC_W+KEY_W-1:FUNC_W];

    // control state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_base,  n_base;
    logic [AW-1:0]   r_addr,  n_addr;
    logic [CW-1:0]   r_left,  n_left;
    logic            r_pend,  n_pend;
    logic [CW-1:0]   r_hits,  n_hits;
    logic            r_ovld,  n_ovld;
    // payload
    logic [KEY_W-1:0] r_probe, n_probe;
    logic [OUT_W-1:0] r_omatch, n_omatch;
    logic [OUT_W-1:0] r_ofill,  n_ofill;

    // RAM port
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [KEY_W-1:0] ram_rdata;

    // index arithmetic around the circular buffer
    logic          full;
    logic [PW-1:0] sum_push, sum_top;
    logic [AW-1:0] idx_push, idx_top, base_inc, addr_inc;
    logic          scan_issue;
    logic          hit;

    assign full     = (r_count == DEPTH_C);
    assign sum_push = PW'(r_base) + PW'(r_count);
    assign sum_top  = sum_push - PW'(1);
    assign idx_push = (sum_push >= DEPTH_P) ? AW'(sum_push - DEPTH_P) : AW'(sum_push);
    assign idx_top  = (sum_top  >= DEPTH_P) ? AW'(sum_top  - DEPTH_P) : AW'(sum_top);
    assign base_inc = (r_base == LAST_A) ? '0 : r_base + AW'(1);
    assign addr_inc = (r_addr == LAST_A) ? '0 : r_addr + AW'(1);

    assign scan_issue = (r_left != '0);
    assign hit        = r_pend && (ram_rdata == r_probe);

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    // write a pushed key: overwrite the oldest when full
    assign ram_we    = in_xfer && (in_func == FN_PUSH);
    assign ram_waddr = full ? r_base : idx_push;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_base   = r_base;
        n_addr   = r_addr;
        n_left   = r_left;
        n_pend   = r_pend;
        n_hits   = r_hits;
        n_probe  = r_probe;
        n_ovld   = r_ovld;
        n_omatch = r_omatch;
        n_ofill  = r_ofill;

        // release the output register once taken
        if (r_ovld && i_m_axis_tready) begin
            n_ovld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_hits = '0;
                    n_pend = 1'b0;
                    n_state = ST_DONE;
                    unique case (in_func)
                        FN_PUSH: begin
                            if (full) begin
                                n_base = base_inc;
                            end else begin
                                n_count = r_count + CW'(1);
                            end
                        end
                        FN_POP: begin
                            if (r_count != '0) begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        FN_CLEAR: begin
                            n_count = '0;
                        end
                        FN_COUNT_KEY: begin
                            n_probe = in_key;
                            n_addr  = r_base;
                            n_left  = r_count;
                            n_state = ST_SCAN;
                        end
                        FN_COUNT_TOP: begin
                            // empty table: nothing to match
                            if (r_count != '0) begin
                                n_addr  = idx_top;
                                n_state = ST_TOPRD;
                            end
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_TOPRD: begin
                n_state = ST_TOPLD;
            end
            ST_TOPLD: begin
                // top key arrives from the RAM: it becomes the probe
                n_probe = ram_rdata;
                n_addr  = r_base;
                n_left  = r_count;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                // issue one read and compare the previous read each cycle
                if (scan_issue) begin
                    n_addr = addr_inc;
                    n_left = r_left - CW'(1);
                end
                n_pend = scan_issue;
                if (hit) begin
                    n_hits = r_hits + CW'(1);
                end
                if (!scan_issue && !r_pend) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold the result until the output register is free
                if (!r_ovld || i_m_axis_tready) begin
                    n_ovld   = 1'b1;
                    n_omatch = OUT_W'(r_hits);
                    n_ofill  = OUT_W'(r_count);
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_base  <= '0;
            r_left  <= '0;
            r_pend  <= 1'b0;
            r_hits  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_base  <= n_base;
            r_left  <= n_left;
            r_pend  <= n_pend;
            r_hits  <= n_hits;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_probe  <= n_probe;
        r_omatch <= n_omatch;
        r_ofill  <= n_ofill;
    end

    hhrc_ram #(
        .WIDTH (KEY_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (in_key),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign o_m_axis_tvalid = r_ovld;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - 2 * OUT_W)'(0), r_ofill, r_omatch};

    `HHRC_NEVER(a_count_bound, i_clk, i_rst_n, r_count > DEPTH_C)
    `HHRC_NEVER(a_base_bound, i_clk, i_rst_n, PW'(r_base) >= DEPTH_P)
    `HHRC_NEVER(a_hits_bound, i_clk, i_rst_n, r_hits > r_count)
    `HHRC_ASSERT(a_push_grows, i_clk, i_rst_n,
        (in_xfer && in_func == FN_PUSH && !full) |=> (r_count == $past(r_count) + CW'(1)))
    `HHRC_ASSERT(a_push_full_rolls, i_clk, i_rst_n,
        (in_xfer && in_func == FN_PUSH && full) |=> (full && r_base != $past(r_base)))

endmodule

@@ dv/hash_history_repeat_counter_tb.sv @@
`timescale 1ns / 100ps

module hash_history_repeat_counter_tb;
    import hhrc_pkg::*;

    localparam int unsigned DEPTH = HISTORY_DEPTH_DEF;

    // Codes past count-top: the block must treat them as no-ops.
    localparam logic [FUNC_W-1:0] FN_UNUSED_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FN_UNUSED_HI = 3'd7;

    localparam int unsigned POOL_SIZE = 8;
    // Drain well past the longest count sweep, which reads DEPTH keys.
    localparam int unsigned DRAIN_CYCLES = DEPTH + 64;

    typedef struct packed {
        logic [OUT_W-1:0] match_count;
        logic [OUT_W-1:0] fill_level;
    } t_repeat_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // [2:0] func, [66:3] key, [71:67] zero
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // [8:0] match_count, [17:9] fill_level, [23:18] zero
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    // Key history as the block should hold it, oldest at the front.
    logic [KEY_W-1:0] key_history[$];
    t_repeat_result   expected_results[$];
    logic [KEY_W-1:0] key_pool[POOL_SIZE];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        recv_hold_off = 1'b0;

    int unsigned mismatch_count = 0;
    int unsigned results_checked = 0;
    int unsigned peak_fill = 0;
    int unsigned peak_matches = 0;

    hash_history_repeat_counter #(
        .HISTORY_DEPTH(DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    function automatic int unsigned count_held(input logic [KEY_W-1:0] probe);
        int unsigned hits;
        hits = 0;
        foreach (key_history[i])
            if (key_history[i] == probe)
                hits++;
        return hits;
    endfunction

    // Apply one operation to the history and return the result it should give.
    function automatic t_repeat_result predict_repeat(input logic [FUNC_W-1:0] fn,
                                                      input logic [KEY_W-1:0] key);
        t_repeat_result res;
        int unsigned    hits;
        hits = 0;
        case (fn)
            FN_PUSH: begin
                // full: drop the oldest key before appending
                if (key_history.size() >= DEPTH)
                    void'(key_history.pop_front());
                key_history.push_back(key);
            end
            FN_POP: begin
                if (key_history.size() > 0)
                    void'(key_history.pop_back());
            end
            FN_CLEAR: key_history.delete();
            FN_COUNT_KEY: hits = count_held(key);
            FN_COUNT_TOP: begin
                if (key_history.size() > 0)
                    hits = count_held(key_history[$]);
            end
            default: ;
        endcase
        res.match_count = OUT_W'(hits);
        res.fill_level  = OUT_W'(key_history.size());
        return res;
    endfunction

    // Offer one operation, hold it until the transfer, then log its result.
    task automatic send_op(input logic [FUNC_W-1:0] fn, input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(IN_TDATA_W - KEY_W - FUNC_W){1'b0}}, key, fn};
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        expected_results.push_back(predict_repeat(fn, key));
    endtask

    task automatic wait_for_drain();
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key(input int unsigned pool_pct);
        if ($urandom_range(99) < pool_pct)
            return key_pool[$urandom_range(POOL_SIZE - 1)];
        return rand_key();
    endfunction

    // Mostly pushes and probes over a small key pool so repeats are common;
    // occasional clears keep the fill level low and the sweeps short.
    task automatic send_random_op();
        int unsigned       roll;
        logic [FUNC_W-1:0] fn;
        roll = $urandom_range(99);
        if (roll < 40)
            fn = FN_PUSH;
        else if (roll < 55)
            fn = FN_POP;
        else if (roll < 58)
            fn = FN_CLEAR;
        else if (roll < 78)
            fn = FN_COUNT_KEY;
        else if (roll < 95)
            fn = FN_COUNT_TOP;
        else
            fn = FUNC_W'($urandom_range(FN_UNUSED_HI, FN_UNUSED_LO));
        send_op(fn, pick_key(70));
    endtask

    // Result checker: compare each transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_repeat_result got;
        t_repeat_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.match_count = o_m_axis_tdata[OUT_W-1:0];
            got.fill_level  = o_m_axis_tdata[2*OUT_W-1:OUT_W];
            if (expected_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result match_count %0d fill_level %0d",
                         $time, got.match_count, got.fill_level);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (got.match_count !== want.match_count) begin
                    mismatch_count++;
                    $display("%0t: match_count expected %0d actual %0d",
                             $time, want.match_count, got.match_count);
                end
                if (got.fill_level !== want.fill_level) begin
                    mismatch_count++;
                    $display("%0t: fill_level expected %0d actual %0d",
                             $time, want.fill_level, got.fill_level);
                end
                if (want.fill_level > peak_fill)
                    peak_fill = want.fill_level;
                if (want.match_count > peak_matches)
                    peak_matches = want.match_count;
            end
        end
    end

    // Receiver: random stalls, or a solid hold-off while one is requested.
    always @(posedge i_clk) begin
        if (recv_hold_off)
            i_m_axis_tready <= 1'b0;
        else
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic test_directed();
        logic [KEY_W-1:0] alt_a;
        logic [KEY_W-1:0] alt_b;
        alt_a = {(KEY_W / 2){2'b10}};
        alt_b = {(KEY_W / 2){2'b01}};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // empty table: pop is ignored, both counts give zero
        send_op(FN_POP, '0);
        send_op(FN_COUNT_TOP, '0);
        send_op(FN_COUNT_KEY, '0);
        send_op(FN_PUSH, '0);
        send_op(FN_PUSH, '1);
        send_op(FN_PUSH, '0);
        send_op(FN_PUSH, alt_a);
        send_op(FN_PUSH, alt_b);
        send_op(FN_COUNT_KEY, '0);
        send_op(FN_COUNT_KEY, '1);
        send_op(FN_COUNT_KEY, alt_a);
        send_op(FN_COUNT_TOP, alt_a);
        // unused codes leave the table alone
        for (int fn = FN_UNUSED_LO; fn <= FN_UNUSED_HI; fn++)
            send_op(FUNC_W'(fn), '1);
        send_op(FN_POP, '1);
        send_op(FN_POP, '0);
        send_op(FN_COUNT_TOP, '1);
        send_op(FN_CLEAR, '1);
        send_op(FN_POP, '0);
        send_op(FN_COUNT_TOP, '0);
        send_op(FN_COUNT_KEY, '0);
        wait_for_drain();
    endtask

    // Fill past the depth so the oldest keys drop out, then saturate the count.
    task automatic test_full_table();
        logic [KEY_W-1:0] first_key;
        logic [KEY_W-1:0] same_key;
        first_key = rand_key();
        same_key  = rand_key();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_op(FN_CLEAR, '0);
        send_op(FN_PUSH, first_key);
        for (int i = 1; i < DEPTH; i++)
            send_op(FN_PUSH, pick_key(25));
        send_op(FN_COUNT_KEY, first_key);
        send_op(FN_COUNT_TOP, '0);
        // push when full: first_key is dropped, fill stays at the depth
        for (int i = 0; i < 24; i++)
            send_op(FN_PUSH, pick_key(50));
        send_op(FN_COUNT_KEY, first_key);
        send_op(FN_COUNT_KEY, key_pool[0]);
        send_op(FN_COUNT_TOP, '0);
        send_op(FN_POP, '0);
        send_op(FN_COUNT_TOP, '0);
        send_op(FN_CLEAR, '0);
        // one key filling every slot gives the largest possible count
        for (int i = 0; i < DEPTH + 8; i++)
            send_op(FN_PUSH, same_key);
        send_op(FN_COUNT_KEY, same_key);
        send_op(FN_COUNT_TOP, '0);
        send_op(FN_COUNT_KEY, ~same_key);
        send_op(FN_CLEAR, '0);
        wait_for_drain();
    endtask

    task automatic test_random_phase(input int unsigned send_pct,
                                     input int unsigned recv_pct,
                                     input int unsigned n_items);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        send_op(FN_CLEAR, '0);
        repeat (n_items)
            send_random_op();
        wait_for_drain();
    endtask

    // Hold the receiver off long enough for the block to stall its input.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        fork
            begin
                @(posedge i_clk);
                recv_hold_off <= 1'b1;
                repeat (600)
                    @(posedge i_clk);
                recv_hold_off <= 1'b0;
            end
        join_none
        repeat (24)
            send_random_op();
        // pause the sender until every result is back, then carry on
        wait_for_drain();
        send_idle_pct = 17;
        repeat (24)
            send_random_op();
        wait_for_drain();
    endtask

    initial begin
        foreach (key_pool[i])
            key_pool[i] = rand_key();
        repeat (8)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_full_table();
        test_random_phase(0, 0, 280);
        test_random_phase(69, 0, 280);
        test_random_phase(0, 69, 280);
        test_random_phase(17, 17, 280);
        test_backpressure();
        repeat (DRAIN_CYCLES)
            @(posedge i_clk);
        $display("Covered push, pop, clear and both counts, unused codes, wrap when full");
        $display("%0d results checked, peak fill %0d, peak match count %0d",
                 results_checked, peak_fill, peak_matches);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
